// ----- hdl/sat_pkg.sv -----
// shared constants and types for the section address translator
package sat_pkg;

    // number of section table slots, one cell each
    localparam int SECTIONS = 16;
    localparam int IDX_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    // field widths
    localparam int ADDR_W    = 32;
    localparam int RAW_W     = 64;
    localparam int SEL_W     = 4;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int OFFSET_W  = ADDR_W + 1;

    // command codes
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_WRITE     = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_HEADER = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_HIT    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 2'd2;

    // transaction as it moves along the row of cells
    typedef struct packed {
        logic                valid;
        logic                cmd;
        logic [ADDR_W-1:0]   rel_address;
        logic [SEL_W-1:0]    entry_index;
        logic [ADDR_W-1:0]   entry_start;
        logic [ADDR_W-1:0]   entry_length;
        logic [ADDR_W-1:0]   entry_raw_offset;
        logic                hit;
        logic [OFFSET_W-1:0] offset;
    } chain_item_t;

endpackage

// ----- hdl/sat_cell.sv -----
// one section slot: holds its window and checks each passing transaction
module sat_cell import sat_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [IDX_W-1:0]   cell_id,
    input  logic [COUNT_W-1:0] section_count,
    input  chain_item_t        item_in,
    output chain_item_t        item_out
);

    logic [ADDR_W-1:0] entry_start_reg;
    logic [ADDR_W-1:0] entry_length_reg;
    logic [ADDR_W-1:0] entry_raw_reg;
    chain_item_t       stage_reg;
    chain_item_t       stage_next;
    logic              valid_reg;
    logic              active;
    logic              in_window;
    logic              slot_write;
    logic [ADDR_W-1:0] win_offset;

    // slot takes part in the search and owns the written index
    assign active     = 32'(cell_id) < 32'(section_count);
    assign slot_write = advance && item_in.valid && (item_in.cmd == CMD_WRITE)
                        && (32'(cell_id) == 32'(item_in.entry_index));

    // window check: address at or above start and less than length beyond it
    assign win_offset = item_in.rel_address - entry_start_reg;
    assign in_window  = active && (item_in.rel_address >= entry_start_reg)
                        && (win_offset < entry_length_reg);

    // first matching slot claims the transaction
    always_comb begin
        stage_next = item_in;
        if (item_in.cmd == CMD_TRANSLATE && !item_in.hit && in_window) begin
            stage_next.hit    = 1'b1;
            stage_next.offset = {1'b0, win_offset} + {1'b0, entry_raw_reg};
        end
    end

    // slot contents, written as a write transaction passes
    always_ff @(posedge aclk) begin
        if (slot_write) begin
            entry_start_reg  <= item_in.entry_start;
            entry_length_reg <= item_in.entry_length;
            entry_raw_reg    <= item_in.entry_raw_offset;
        end
    end

    // stage register towards the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            stage_reg <= stage_next;
        end
    end

    always_comb begin
        item_out       = stage_reg;
        item_out.valid = valid_reg;
    end

endmodule

// ----- hdl/sat_out.sv -----
// result stage: header bypass, base addition and status
module sat_out import sat_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [ADDR_W-1:0]   header_size,
    input  logic [RAW_W-1:0]    base_address,
    input  chain_item_t         item_in,
    output logic                m_valid,
    output logic [RAW_W-1:0]    m_raw_address,
    output logic [STATUS_W-1:0] m_status
);

    logic                valid_reg;
    logic                valid_next;
    logic [RAW_W-1:0]    raw_reg;
    logic [RAW_W-1:0]    raw_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    // only translate transactions give a result
    assign valid_next = item_in.valid && (item_in.cmd == CMD_TRANSLATE);

    // header region wins over any section hit
    always_comb begin
        priority if (item_in.rel_address < header_size) begin
            raw_next    = base_address + RAW_W'(item_in.rel_address);
            status_next = STAT_HEADER;
        end else if (item_in.hit) begin
            raw_next    = base_address + RAW_W'(item_in.offset);
            status_next = STAT_HIT;
        end else begin
            raw_next    = '0;
            status_next = STAT_MISS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            raw_reg    <= raw_next;
            status_reg <= status_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_raw_address = raw_reg;
    assign m_status      = status_reg;

endmodule

// ----- hdl/section_address_translator.sv -----
// top level: configuration registers, row of section cells and result stage
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    cmd, rel_address, entry_*
//  m_        out        m_valid/m_ready    raw_address, status
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// one transaction per cycle enters while the row is not held; each passes SECTIONS
// cell stages and then the result stage, where its result is registered.
// write transactions update their slot as they pass and give no result.
// the whole row holds while a result waits on m_ready; s_ready follows it.
// aresetn clears the configuration registers and all valid flags; slot
// contents are undefined until written.
module section_address_translator import sat_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [ADDR_W-1:0]    s_rel_address,
    input  logic [SEL_W-1:0]     s_entry_index,
    input  logic [ADDR_W-1:0]    s_entry_start,
    input  logic [ADDR_W-1:0]    s_entry_length,
    input  logic [ADDR_W-1:0]    s_entry_raw_offset,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [RAW_W-1:0]     m_raw_address,
    output logic [STATUS_W-1:0]  m_status
);

    logic [ADDR_W-1:0]  header_size_reg;
    logic [RAW_W-1:0]   base_address_reg;
    logic [COUNT_W-1:0] section_count_reg;
    logic               advance;
    chain_item_t        head_item;
    chain_item_t        chain [SECTIONS+1];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_size_reg   <= '0;
            base_address_reg  <= '0;
            section_count_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HEADER_SIZE:   header_size_reg   <= cfg_wdata[ADDR_W-1:0];
                REG_BASE_ADDRESS:  base_address_reg  <= cfg_wdata;
                REG_SECTION_COUNT: section_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // row moves whenever the result register is free or being emptied
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // incoming transaction at the head of the row
    always_comb begin
        head_item                  = '0;
        head_item.valid            = s_valid;
        head_item.cmd              = s_cmd;
        head_item.rel_address      = s_rel_address;
        head_item.entry_index      = s_entry_index;
        head_item.entry_start      = s_entry_start;
        head_item.entry_length     = s_entry_length;
        head_item.entry_raw_offset = s_entry_raw_offset;
    end

    assign chain[0] = head_item;

    // row of section cells
    for (genvar g = 0; g < SECTIONS; g++) begin : g_cell
        sat_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .advance       (advance),
            .cell_id       (IDX_W'(g)),
            .section_count (section_count_reg),
            .item_in       (chain[g]),
            .item_out      (chain[g+1])
        );
    end

    // result stage
    sat_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .header_size   (header_size_reg),
        .base_address  (base_address_reg),
        .item_in       (chain[SECTIONS]),
        .m_valid       (m_valid),
        .m_raw_address (m_raw_address),
        .m_status      (m_status)
    );

    // a miss always reports a zero address
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_MISS) |-> (m_raw_address == '0))
        else $error("miss result with non-zero address");

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_HEADER || m_status == STAT_HIT
                     || m_status == STAT_MISS))
        else $error("undefined status code");

    // input is held off only while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a waiting result");

    // a write transaction leaving the row gives no result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && chain[SECTIONS].valid && chain[SECTIONS].cmd == CMD_WRITE)
        |=> !m_valid)
        else $error("write transaction produced a result");

endmodule
